// File: hdl/sldf_pkg.sv
// sldf_pkg: shared types and constants of the sync/length/XOR deframer.
// Depends on nothing; the core, queue, top level and testbench import it.
package sldf_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h96;
    localparam logic [7:0] SYNC_SECOND = 8'h69;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_CUT  = 2'd3
    } t_kind;

    // One result item as it travels from the core to the output queue
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] frame_length;
        logic        last;
    } t_result;

endpackage

// File: hdl/sldf_if.sv
// sldf_if: valid/ready channel interfaces for the deframer's input and output items.
// Depends on nothing; the top level uses both.
interface sldf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       chunk_end;

    modport source (output valid, input ready, output rx_byte, output chunk_end);
    modport sink   (input valid, output ready, input rx_byte, input chunk_end);
endinterface

interface sldf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic        last;

    modport source (output valid, input ready, output kind, output payload_byte,
                    output frame_length, output last);
    modport sink   (input valid, output ready, input kind, input payload_byte,
                    input frame_length, input last);
endinterface

// File: hdl/sldf_core.sv
// sldf_core: frame parser state machine; turns one accepted byte into zero to two results.
// Depends on sldf_pkg.
module sldf_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_chunk_end,
    output logic [1:0]        o_count,
    output sldf_pkg::t_result o_res0,
    output sldf_pkg::t_result o_res1
);
    import sldf_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] len_lo;
    logic [15:0] rem_dec;
    logic        in_frame;

    assign len_lo  = r_len | {8'h00, i_rx_byte};
    assign rem_dec = r_rem - 16'd1;

    // Next state and results for the byte on the input
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_rem   = r_rem;
        n_xor   = r_xor;
        o_count = 2'd0;
        o_res0  = '0;
        o_res1  = '0;

        case (r_phase)
            PH_SYNC1: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_phase = PH_LENHI;
                    n_len   = '0;
                    n_rem   = '0;
                    n_xor   = '0;
                end else if (i_rx_byte != SYNC_FIRST) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LENHI: begin
                n_len   = {i_rx_byte, 8'h00};
                n_xor   = i_rx_byte;
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                n_len   = len_lo;
                n_rem   = len_lo;
                n_xor   = r_xor ^ i_rx_byte;
                n_phase = (len_lo == 16'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                o_res0.kind         = KIND_DATA;
                o_res0.payload_byte = i_rx_byte;
                o_count             = 2'd1;
                n_xor               = r_xor ^ i_rx_byte;
                n_rem               = rem_dec;
                if (rem_dec == 16'd0) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_res0.kind         = (i_rx_byte == r_xor) ? KIND_OK : KIND_BAD;
                o_res0.frame_length = r_len;
                o_count             = 2'd1;
                n_phase             = PH_HUNT;
                n_len               = '0;
                n_rem               = '0;
                n_xor               = '0;
            end
            default: begin
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
            end
        endcase

        in_frame = (n_phase == PH_LENHI) || (n_phase == PH_LENLO) ||
                   (n_phase == PH_DATA)  || (n_phase == PH_CHECK);

        // Abort a partial frame at the end of a chunk
        if (i_chunk_end) begin
            if (in_frame) begin
                if (o_count == 2'd0) begin
                    o_res0.kind         = KIND_CUT;
                    o_res0.frame_length = n_len;
                    o_count             = 2'd1;
                end else begin
                    o_res1.kind         = KIND_CUT;
                    o_res1.frame_length = n_len;
                    o_count             = 2'd2;
                end
            end
            n_phase = PH_HUNT;
            n_len   = '0;
            n_rem   = '0;
            n_xor   = '0;
        end

        // Flag the final result of this byte
        o_res0.last = (o_count == 2'd1);
        o_res1.last = (o_count == 2'd2);
    end

    // Hold parser state; advance on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_rem   <= '0;
            r_xor   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_xor   <= n_xor;
        end
    end

endmodule

// File: hdl/sldf_queue.sv
// sldf_queue: result queue taking up to two results a cycle and giving out one.
// Depends on sldf_pkg.
module sldf_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_count,
    input  sldf_pkg::t_result i_res0,
    input  sldf_pkg::t_result i_res1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_pop,
    output sldf_pkg::t_result o_head
);
    import sldf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   wr_ptr_1;
    logic            pop_ok;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr_1 = ptr_inc(r_wr_ptr);
    assign o_room   = (r_count <= CW'(DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign pop_ok   = i_pop && o_valid;

    always_comb begin
        case (i_push_count)
            2'd1:    n_wr_ptr = wr_ptr_1;
            2'd2:    n_wr_ptr = ptr_inc(wr_ptr_1);
            default: n_wr_ptr = r_wr_ptr;
        endcase
    end

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_res1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            if (pop_ok) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + CW'(i_push_count) - CW'(pop_ok);
        end
    end

endmodule

// File: hdl/sync_length_xor_deframer.sv
// sync_length_xor_deframer: top level of the serial frame deframer.
// Depends on sldf_pkg, sldf_if, sldf_core and sldf_queue.
//
// Usage:
//   i_in carries received bytes (rx_byte) with a chunk_end mark; o_out carries
//   result items: payload bytes (kind 0) and frame status (ok, checksum
//   mismatch, cut short) with the frame length, and last on the final result
//   of each input byte. Frames are 0x96 0x69, length high, length low,
//   payload, XOR check byte.
//   Each result is written into the result queue when its byte is taken and
//   is offered on o_out in order. One byte is taken per cycle while the queue
//   has room. A byte that ends a chunk inside a payload gives two results,
//   which leave o_out one after another. i_in.ready is high while the result
//   queue has room for two results; the queue holds QUEUE_DEPTH results.
//   Reset returns the parser to hunting for the first sync byte and empties
//   the result queue; nothing is delivered after reset until new bytes come.
module sync_length_xor_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sldf_in_if.sink    i_in,
    sldf_out_if.source o_out
);
    import sldf_pkg::*;

    logic       accept;
    logic       room;
    logic [1:0] core_count;
    logic [1:0] push_count;
    t_result    res0, res1, head;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    // Parse the accepted byte
    sldf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_in.rx_byte),
        .i_chunk_end (i_in.chunk_end),
        .o_count     (core_count),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    // Drop results of cycles without an accepted item
    assign push_count = accept ? core_count : 2'd0;

    sldf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (res0),
        .i_res1       (res1),
        .o_room       (room),
        .o_valid      (o_out.valid),
        .i_pop        (o_out.ready),
        .o_head       (head)
    );

    assign o_out.kind         = head.kind;
    assign o_out.payload_byte = head.payload_byte;
    assign o_out.frame_length = head.frame_length;
    assign o_out.last         = head.last;

endmodule

// File: sim/tb_sync_length_xor_deframer.sv
// tb_sync_length_xor_deframer: self-checking testbench of the sync/length/XOR deframer.
// Predicts payload and status items per received byte and checks every output item.
// Depends on sldf_pkg, sldf_if and sync_length_xor_deframer.
`timescale 1ns / 1ps

module tb_sync_length_xor_deframer;
    import sldf_pkg::*;

    // Parser position as the predictor tracks it
    typedef enum logic [2:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        TAKE_LEN_HI,
        TAKE_LEN_LO,
        TAKE_PAYLOAD,
        TAKE_CHECK
    } t_parse_phase;

    // Tracks frame state and holds the items each accepted byte should produce
    class t_deframe_board;
        t_parse_phase phase;
        logic [15:0]  frame_len;
        logic [15:0]  bytes_left;
        logic [7:0]   xor_acc;
        t_result      due_results[$];
        int           errors;

        function new();
            reset_frame();
            errors = 0;
        endfunction

        function void reset_frame();
            phase      = SEEK_FIRST;
            frame_len  = '0;
            bytes_left = '0;
            xor_acc    = '0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void push_due(t_kind k, logic [7:0] pb, logic [15:0] fl);
            t_result r;
            r.kind         = k;
            r.payload_byte = pb;
            r.frame_length = fl;
            r.last         = 1'b0;
            due_results.push_back(r);
        endfunction

        // Advance the parse state by one accepted byte and queue its items
        function void note_byte(logic [7:0] b, logic chunk_end);
            int n;
            n = 0;
            case (phase)
                SEEK_SECOND: begin
                    if (b == SYNC_SECOND) begin
                        phase      = TAKE_LEN_HI;
                        frame_len  = '0;
                        bytes_left = '0;
                        xor_acc    = '0;
                    end else if (b != SYNC_FIRST) begin
                        phase = SEEK_FIRST;
                    end
                end
                TAKE_LEN_HI: begin
                    frame_len = {b, 8'h00};
                    xor_acc   = b;
                    phase     = TAKE_LEN_LO;
                end
                TAKE_LEN_LO: begin
                    frame_len[7:0] = b;
                    xor_acc        = xor_acc ^ b;
                    bytes_left     = frame_len;
                    phase          = (frame_len == 16'd0) ? TAKE_CHECK : TAKE_PAYLOAD;
                end
                TAKE_PAYLOAD: begin
                    push_due(KIND_DATA, b, 16'd0);
                    n++;
                    xor_acc    = xor_acc ^ b;
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 16'd0) phase = TAKE_CHECK;
                end
                TAKE_CHECK: begin
                    push_due((b == xor_acc) ? KIND_OK : KIND_BAD, 8'h00, frame_len);
                    n++;
                    reset_frame();
                end
                default: begin
                    phase = (b == SYNC_FIRST) ? SEEK_SECOND : SEEK_FIRST;
                end
            endcase

            // A chunk boundary inside a frame cuts it short
            if (chunk_end) begin
                if (phase != SEEK_FIRST && phase != SEEK_SECOND) begin
                    push_due(KIND_CUT, 8'h00, frame_len);
                    n++;
                end
                reset_frame();
            end

            if (n > 0) due_results[due_results.size() - 1].last = 1'b1;
        endfunction

        // Compare one output item against the oldest expectation
        function void check_result(logic [1:0] kind, logic [7:0] pb, logic [15:0] fl,
                                   logic last);
            t_result exp_r;
            if (due_results.size() == 0) begin
                $error("unexpected item: kind %0d payload_byte 0x%02h frame_length %0d",
                       kind, pb, fl);
                errors++;
                return;
            end
            exp_r = due_results.pop_front();
            if (kind !== exp_r.kind) begin
                $error("kind: expected %0d, actual %0d", exp_r.kind, kind);
                errors++;
            end
            if (pb !== exp_r.payload_byte) begin
                $error("payload_byte: expected 0x%02h, actual 0x%02h", exp_r.payload_byte, pb);
                errors++;
            end
            if (fl !== exp_r.frame_length) begin
                $error("frame_length: expected 0x%04h, actual 0x%04h", exp_r.frame_length, fl);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last: expected %0b, actual %0b", exp_r.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int NUM_ITEMS    = 850;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sldf_in_if  in_if();
    sldf_out_if out_if();

    t_deframe_board board = new();

    int sent_count  = 0;
    bit rx_hold_req = 1'b0;
    int hold_left   = 0;
    int stall_left  = 0;

    // {chunk_end, rx_byte}
    logic [8:0] opening_seq [25] = '{
        // zero length, good check, chunk ends on the check byte (no cut)
        9'h096, 9'h069, 9'h000, 9'h000, 9'h100,
        // stray byte after the first sync byte: back to hunting
        9'h096, 9'h055,
        // repeated first sync byte, one payload byte, wrong check
        9'h096, 9'h096, 9'h069, 9'h000, 9'h001, 9'h0FF, 9'h000,
        // largest length, chunk ends on the first payload byte
        9'h096, 9'h069, 9'h0FF, 9'h0FF, 9'h100,
        // lone first sync byte at chunk end is dropped
        9'h196,
        // chunk ends right after the sync pair
        9'h096, 9'h169,
        // chunk ends after the high length byte
        9'h096, 9'h069, 9'h112
    };

    sync_length_xor_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // Idling runs in stretches and stops for the last part of the run
    function automatic bit idle_allowed();
        return (sent_count < 700) && ((sent_count / 120) % 3 != 2);
    endfunction

    // Offer one byte and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic ce);
        if (idle_allowed() && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.rx_byte   <= b;
        in_if.chunk_end <= ce;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_byte(b, ce);
        sent_count++;
    endtask

    // Stop offering until every expected item has come out
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Build one frame (good, bad check or cut short) or a run of noise and send it
    task automatic send_random_frame();
        logic [7:0]  body[$];
        logic [15:0] len;
        logic [7:0]  chk;
        logic [7:0]  pb;
        int          mode;
        int          n;
        int          drop;
        int          pick;
        mode = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0) body.push_back(SYNC_FIRST);

        // noise, leaning on the sync values
        if (mode < 15) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                pick = $urandom_range(0, 3);
                pb   = (pick == 0) ? SYNC_FIRST : (pick == 1) ? SYNC_SECOND
                                                            : 8'($urandom_range(0, 255));
                send_byte(pb, $urandom_range(0, 7) == 0);
            end
            return;
        end

        if (mode < 85)
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 40))
                                              : 16'($urandom_range(0, 8));
        else
            len = 16'($urandom_range(0, 65535));

        body.push_back(SYNC_FIRST);
        body.push_back(SYNC_SECOND);
        body.push_back(len[15:8]);
        body.push_back(len[7:0]);
        chk = len[15:8] ^ len[7:0];

        if (mode >= 85) begin
            // cut short inside the header or the payload
            n = $urandom_range(0, 6);
            if (n > int'(len)) n = int'(len);
            for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
            if (n == 0) begin
                drop = $urandom_range(0, 3);
                for (int i = 0; i < drop && body.size() > 1; i++) void'(body.pop_back());
            end
            for (int i = 0; i < body.size(); i++)
                send_byte(body[i], i == body.size() - 1);
        end else begin
            for (int i = 0; i < int'(len); i++) begin
                pb = ($urandom_range(0, 15) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255));
                body.push_back(pb);
                chk = chk ^ pb;
            end
            if (mode >= 75) chk = chk ^ 8'($urandom_range(1, 255));
            body.push_back(chk);
            for (int i = 0; i < body.size(); i++)
                send_byte(body[i], (i == body.size() - 1) && ($urandom_range(0, 5) == 0));
        end
    endtask

    // Check output items and drive ready with random stalls and one long hold
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_result(out_if.kind, out_if.payload_byte, out_if.frame_length,
                               out_if.last);
        if (rx_hold_req) begin
            hold_left   = HOLD_CYCLES;
            rx_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Stimulus and end of run
    initial begin
        int  drain;
        bit  held;
        bit  paused;
        held   = 1'b0;
        paused = 1'b0;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.rx_byte   <= 8'h00;
        in_if.chunk_end <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_seq[i]) send_byte(opening_seq[i][7:0], opening_seq[i][8]);
        wait_drained();

        while (sent_count < NUM_ITEMS) begin
            if (!held && sent_count >= 250) begin
                rx_hold_req = 1'b1;
                held        = 1'b1;
            end
            if (!paused && sent_count >= 400) begin
                wait_drained();
                paused = 1'b1;
            end
            send_random_frame();
        end
        in_if.valid <= 1'b0;

        drain = 0;
        while (board.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d expected items never arrived", board.pending());
            board.errors++;
        end

        if (board.errors == 0)
            $display("tb_sync_length_xor_deframer: done, clean");
        else
            $display("tb_sync_length_xor_deframer: done, errors");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #(64'd8_000_000);
        $display("tb_sync_length_xor_deframer: done, errors");
        $finish;
    end

endmodule
